### hdl/dhp_pkg.sv
// ============================================================================
// dhp_pkg
// Shared types and constants for the double-hashing lookup table.
// ============================================================================
package dhp_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_WIDTH   = 32;
    localparam int HASH_W      = 32;
    localparam int POS_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = POS_W + 1;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 2;

    // remainder unit: bits retired per cycle and steps per 32-bit dividend
    localparam int REM_BITS    = 4;
    localparam int REM_STEPS   = HASH_W / REM_BITS;
    localparam int STEP_W      = $clog2(REM_STEPS);

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_TABLE_SIZE = 2'd0;
    localparam logic [SIZE_W-1:0]  TABLE_SIZE_RESET = SIZE_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_MISS,
        ST_MOD,
        ST_SEED,
        ST_READ,
        ST_CHECK
    } dhp_state_t;

    typedef struct packed {
        logic load;
        logic rem_step;
        logic seed;
        logic mem_write;
        logic mem_read;
        logic advance;
        logic finish_write;
        logic finish_hit;
        logic finish_miss;
    } dhp_cmd_t;

    typedef struct packed {
        logic size_zero;
        logic held_empty;
        logic held_match;
        logic last_probe;
    } dhp_status_t;

endpackage

### hdl/double_hash_probe_lookup.sv
// ============================================================================
// double_hash_probe_lookup
// Open-addressed key table searched by double hashing, with a slot write path.
// ============================================================================
// A transfer is taken when start is high and busy is low; one result follows
// on done for a single cycle and cannot be held off. A write passes through
// the WRITE state to a registered done. A lookup first reduces hash_one,
// hash_two and 2^32 modulo table_size in a remainder unit that retires four
// bits a cycle, then walks the probe chain, each probe a READ state for the
// registered read of the single slot memory and then a CHECK state. A lookup
// with table_size zero goes straight to a miss. Values of table_size above
// 256 act as 256. The table reads empty after reset with no clearing pass.
// busy drops in the cycle done is shown, so the next transfer may be taken
// alongside a result.
module double_hash_probe_lookup
    import dhp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic [KEY_WIDTH-1:0] key,
    input  logic [HASH_W-1:0]    hash_one,
    input  logic [HASH_W-1:0]    hash_two,
    input  logic [POS_W-1:0]     slot_index,
    output logic                 done,
    output logic                 found,
    output logic [POS_W-1:0]     position,
    output logic [KEY_WIDTH-1:0] stored_value,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    dhp_cmd_t          cmd;
    dhp_status_t       status;
    logic [SIZE_W-1:0] table_size_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_TABLE_SIZE))
        begin
            table_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_TABLE_SIZE) ? DATA_W'(table_size_reg) : '0;

    dhp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    dhp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .table_size   (table_size_reg),
        .key          (key),
        .hash_one     (hash_one),
        .hash_two     (hash_two),
        .slot_index   (slot_index),
        .done         (done),
        .found        (found),
        .position     (position),
        .stored_value (stored_value)
    );

endmodule

### hdl/dhp_rem_lane.sv
// ============================================================================
// dhp_rem_lane
// Radix-16 restoring remainder: 32-bit dividend modulo a 9-bit divisor,
// four bits per cycle while step is high.
// ============================================================================
module dhp_rem_lane
    import dhp_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic [HASH_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic [POS_W-1:0]  rem
);

    logic [HASH_W-1:0] div_reg;
    logic [HASH_W-1:0] div_next;
    logic [POS_W-1:0]  rem_reg;
    logic [POS_W-1:0]  rem_next;

    always_comb
    begin
        logic [SIZE_W:0]     r;
        logic [HASH_W-1:0]   d;
        r = {2'b00, rem_reg};
        d = div_reg;
        for (int k = 0; k < REM_BITS; k++)
        begin
            r = {r[SIZE_W-1:0], d[HASH_W-1]};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
            end
            d = {d[HASH_W-2:0], 1'b0};
        end
        rem_next = r[POS_W-1:0];
        div_next = d;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= '0;
            div_reg <= dividend;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            div_reg <= div_next;
        end
    end

    assign rem = rem_reg;

endmodule

### hdl/dhp_datapath.sv
// ============================================================================
// dhp_datapath
// Slot memory, probe position arithmetic, request and result registers.
// ============================================================================
module dhp_datapath
    import dhp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dhp_cmd_t             cmd,
    output dhp_status_t          status,
    input  logic [SIZE_W-1:0]    table_size,
    input  logic [KEY_WIDTH-1:0] key,
    input  logic [HASH_W-1:0]    hash_one,
    input  logic [HASH_W-1:0]    hash_two,
    input  logic [POS_W-1:0]     slot_index,
    output logic                 done,
    output logic                 found,
    output logic [POS_W-1:0]     position,
    output logic [KEY_WIDTH-1:0] stored_value
);

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [HASH_W-1:0]    h1_reg;
    logic [HASH_W-1:0]    h2_reg;
    logic [POS_W-1:0]     slot_reg;
    logic [SIZE_W-1:0]    n_reg;
    logic [SIZE_W-1:0]    active_size;

    logic [HASH_W-1:0]    addr_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [POS_W-1:0]     idx_reg;
    logic [HASH_W:0]      addr_sum;

    logic [POS_W-1:0]     h1_mod;
    logic [POS_W-1:0]     h2_mod;
    logic [POS_W-1:0]     wrap_mod;
    logic [HASH_W-1:0]    neg_size;

    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [KEY_WIDTH-1:0] held;

    logic                 done_reg;
    logic                 found_reg;
    logic [POS_W-1:0]     position_reg;
    logic [KEY_WIDTH-1:0] value_reg;

    assign active_size = (table_size > TABLE_SIZE_RESET) ? TABLE_SIZE_RESET : table_size;
    // 2^32 mod n equals (2^32 - n) mod n
    assign neg_size    = HASH_W'(0) - HASH_W'(active_size);

    dhp_rem_lane u_rem_h1 (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.rem_step),
        .dividend (hash_one),
        .divisor  (n_reg),
        .rem      (h1_mod)
    );

    dhp_rem_lane u_rem_h2 (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.rem_step),
        .dividend (hash_two),
        .divisor  (n_reg),
        .rem      (h2_mod)
    );

    dhp_rem_lane u_rem_wrap (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.rem_step),
        .dividend (neg_size),
        .divisor  (n_reg),
        .rem      (wrap_mod)
    );

    // next probe: add the step modulo n, and take back 2^32 mod n on wrap
    assign addr_sum = {1'b0, addr_reg} + {1'b0, h2_reg};

    always_comb
    begin
        logic [SIZE_W:0] t1;
        logic [SIZE_W:0] t;
        logic [SIZE_W:0] wm;
        logic [SIZE_W:0] nn;
        nn = {1'b0, n_reg};
        wm = {2'b00, wrap_mod};
        t1 = {2'b00, pos_reg} + {2'b00, h2_mod};
        t  = (t1 >= nn) ? (t1 - nn) : t1;
        if (addr_sum[HASH_W])
        begin
            t = (t >= wm) ? (t - wm) : (t + nn - wm);
        end
        pos_next = t[POS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key;
            h1_reg   <= hash_one;
            h2_reg   <= hash_two;
            slot_reg <= slot_index;
            n_reg    <= active_size;
        end
        if (cmd.seed)
        begin
            addr_reg <= h1_reg;
            pos_reg  <= h1_mod;
            idx_reg  <= '0;
        end
        else if (cmd.advance)
        begin
            addr_reg <= addr_sum[HASH_W-1:0];
            pos_reg  <= pos_next;
            idx_reg  <= idx_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[slot_reg] <= key_reg;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg  <= mem[pos_reg];
            rd_valid_reg <= valid_reg[pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.mem_write)
        begin
            valid_reg[slot_reg] <= 1'b1;
        end
    end

    // a slot never written reads as empty
    assign held = rd_valid_reg ? rd_data_reg : '0;

    assign status.size_zero  = (active_size == '0);
    assign status.held_empty = (held == '0);
    assign status.held_match = (held == key_reg);
    assign status.last_probe = (({1'b0, idx_reg} + SIZE_W'(1)) == n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish_write | cmd.finish_hit | cmd.finish_miss;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_write)
        begin
            found_reg    <= 1'b1;
            position_reg <= slot_reg;
            value_reg    <= key_reg;
        end
        else if (cmd.finish_hit)
        begin
            found_reg    <= 1'b1;
            position_reg <= pos_reg;
            value_reg    <= held;
        end
        else if (cmd.finish_miss)
        begin
            found_reg    <= 1'b0;
            position_reg <= '0;
            value_reg    <= '0;
        end
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign position     = position_reg;
    assign stored_value = value_reg;

endmodule

### hdl/dhp_ctrl.sv
// ============================================================================
// dhp_ctrl
// Sequencer for write, remainder setup and probe loop.
// ============================================================================
module dhp_ctrl
    import dhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        req_type,
    input  dhp_status_t status,
    output dhp_cmd_t    cmd,
    output logic        busy
);

    dhp_state_t        state_reg;
    dhp_state_t        state_next;
    logic [STEP_W-1:0] step_cnt_reg;
    logic [STEP_W-1:0] step_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        busy          = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load      = 1'b1;
                    step_cnt_next = '0;
                    if (req_type == REQ_WRITE)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (status.size_zero)
                    begin
                        state_next = ST_MISS;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_WRITE:
            begin
                cmd.mem_write    = 1'b1;
                cmd.finish_write = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_MISS:
            begin
                cmd.finish_miss = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_MOD:
            begin
                cmd.rem_step  = 1'b1;
                step_cnt_next = step_cnt_reg + STEP_W'(1);
                if (step_cnt_reg == STEP_W'(REM_STEPS - 1))
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                // empty test first: key zero must never report a hit
                if (status.held_empty)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (status.held_match)
                begin
                    cmd.finish_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (status.last_probe)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/dhp_checker.sv
// ============================================================================
// dhp_checker
// Port-level checks on the lookup block, attached to the top level by bind.
// ============================================================================
module dhp_checker
    import dhp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic                 found,
    input logic [POS_W-1:0]     position,
    input logic [KEY_WIDTH-1:0] stored_value
);

    // an accepted transfer occupies the block in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transfer");

    // a result is only shown once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // every item ends with its result as busy drops
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (position == '0 && stored_value == '0))
        else $error("miss result carries nonzero payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind double_hash_probe_lookup dhp_checker u_dhp_checker (.*);

### test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the double-hashing key table: a directed table of
// writes and lookups over several table sizes, then random writes and lookups
// with sender idling, checked by row expectations or an in-bench probe model.
// ============================================================================
module tb;
    import dhp_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 3000000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 16;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 106;
    localparam int POOL_N          = 24;
    localparam int PRINT_CAP       = 50;

    typedef struct packed {
        logic                 found;
        logic [POS_W-1:0]     position;
        logic [KEY_WIDTH-1:0] stored_value;
    } lookup_result_t;

    typedef struct {
        logic                 cfg_en;
        logic [DATA_W-1:0]    cfg_val;
        logic                 req;
        logic [KEY_WIDTH-1:0] key;
        logic [HASH_W-1:0]    h1;
        logic [HASH_W-1:0]    h2;
        logic [POS_W-1:0]     slot;
        logic                 typed;
        lookup_result_t       want;
    } stim_row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic                 req_type     = REQ_LOOKUP;
    logic [KEY_WIDTH-1:0] key          = '0;
    logic [HASH_W-1:0]    hash_one     = '0;
    logic [HASH_W-1:0]    hash_two     = '0;
    logic [POS_W-1:0]     slot_index   = '0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [PADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]    pwdata       = '0;
    logic                 busy;
    logic                 done;
    logic                 found;
    logic [POS_W-1:0]     position;
    logic [KEY_WIDTH-1:0] stored_value;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // probe model state
    logic [KEY_WIDTH-1:0] slot_keys [TABLE_DEPTH];
    logic [SIZE_W-1:0]    size_cfg;

    lookup_result_t       pending_results [$];
    stim_row_t            dir_rows [$];
    int                   err_count   = 0;
    int                   idle_pct    = 0;
    int                   cycle_count = 0;

    logic [KEY_WIDTH-1:0] pool_key [POOL_N];
    logic [HASH_W-1:0]    pool_h1  [POOL_N];
    logic [HASH_W-1:0]    pool_h2  [POOL_N];

    int unsigned PHASE_SIZES [N_PHASES] = '{256, 1, 2, 511, 0, 17, 300, 64};
    int          PHASE_IDLE  [N_PHASES] = '{0, 48, 0, 10, 0, 48, 0, 10};

    double_hash_probe_lookup u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .key          (key),
        .hash_one     (hash_one),
        .hash_two     (hash_two),
        .slot_index   (slot_index),
        .done         (done),
        .found        (found),
        .position     (position),
        .stored_value (stored_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("MISMATCH %s: got %h expected %h at cycle %0d",
                     what, got, want, cycle_count);
    endtask

    function automatic int unsigned active_slots();
        return (size_cfg > SIZE_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(size_cfg);
    endfunction

    function automatic logic [31:0] probe_slot(input logic [HASH_W-1:0] h1,
                                               input logic [HASH_W-1:0] h2,
                                               input int unsigned i,
                                               input int unsigned n);
        logic [31:0] step;
        logic [31:0] addr;
        logic [31:0] idx;
        logic [31:0] modulus;
        idx     = i;
        modulus = n;
        step    = h2 * idx;
        addr    = h1 + step;
        return addr % modulus;
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [KEY_WIDTH-1:0] k,
                                                      input logic [HASH_W-1:0] h1,
                                                      input logic [HASH_W-1:0] h2);
        lookup_result_t r;
        int unsigned    n;
        logic [31:0]    pos;
        r = '0;
        n = active_slots();
        for (int unsigned i = 0; i < n; i++)
        begin
            pos = probe_slot(h1, h2, i, n);
            if (slot_keys[pos[POS_W-1:0]] == '0)
                break;
            if (slot_keys[pos[POS_W-1:0]] == k)
            begin
                r.found        = 1'b1;
                r.position     = pos[POS_W-1:0];
                r.stored_value = slot_keys[pos[POS_W-1:0]];
                break;
            end
        end
        return r;
    endfunction

    function automatic lookup_result_t store_key(input logic [POS_W-1:0] slot,
                                                 input logic [KEY_WIDTH-1:0] k);
        lookup_result_t r;
        slot_keys[slot] = k;
        r.found         = 1'b1;
        r.position      = slot;
        r.stored_value  = k;
        return r;
    endfunction

    // first empty slot on the probe path, or -1 when the path is full
    function automatic int free_slot(input logic [HASH_W-1:0] h1,
                                     input logic [HASH_W-1:0] h2);
        int unsigned n;
        logic [31:0] pos;
        n = active_slots();
        for (int unsigned i = 0; i < n; i++)
        begin
            pos = probe_slot(h1, h2, i, n);
            if (slot_keys[pos[POS_W-1:0]] == '0)
                return int'(pos);
        end
        return -1;
    endfunction

    function automatic void add_row(input logic cfg_en, input logic [31:0] cfg_val,
                                    input logic req, input logic [31:0] k,
                                    input logic [31:0] h1, input logic [31:0] h2,
                                    input logic [7:0] slot, input logic typed,
                                    input logic f, input logic [7:0] p,
                                    input logic [31:0] v);
        stim_row_t row;
        row.cfg_en  = cfg_en;
        row.cfg_val = cfg_val;
        row.req     = req;
        row.key     = k;
        row.h1      = h1;
        row.h2      = h2;
        row.slot    = slot;
        row.typed   = typed;
        row.want    = '{found: f, position: p, stored_value: v};
        dir_rows.push_back(row);
    endfunction

    // Result monitor: every strobe must match the oldest pending expectation.
    always @(posedge clk)
    begin
        lookup_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", stored_value, '0);
            else
            begin
                exp_r = pending_results.pop_front();
                if (found !== exp_r.found)
                    report_mismatch("found", 32'(found), 32'(exp_r.found));
                if (position !== exp_r.position)
                    report_mismatch("position", 32'(position), 32'(exp_r.position));
                if (stored_value !== exp_r.stored_value)
                    report_mismatch("stored_value", stored_value, exp_r.stored_value);
            end
        end
    end

    // Issue one transfer; start stays high on return so a follow-on item can
    // go out back to back. Callers that stop issuing must drop start.
    task automatic drive_item(input logic req, input logic [KEY_WIDTH-1:0] k,
                              input logic [HASH_W-1:0] h1, input logic [HASH_W-1:0] h2,
                              input logic [POS_W-1:0] slot, input logic typed,
                              input lookup_result_t want);
        lookup_result_t exp_r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= req;
        key        <= k;
        hash_one   <= h1;
        hash_two   <= h2;
        slot_index <= slot;
        do
            @(posedge clk);
        while (busy);
        if (req == REQ_WRITE)
            exp_r = store_key(slot, k);
        else
            exp_r = predict_lookup(k, h1, h2);
        if (typed)
            exp_r = want;
        pending_results.push_back(exp_r);
    endtask

    // Register write, only with the block drained.
    task automatic set_table_size(input logic [DATA_W-1:0] val);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TABLE_SIZE;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        size_cfg  = val[SIZE_W-1:0];
    endtask

    initial
    begin
        stim_row_t      row;
        lookup_result_t no_want;
        int             free;
        int             pick;
        int             pidx;
        int             drain;
        logic [POS_W-1:0]     slot;
        logic [KEY_WIDTH-1:0] k;

        no_want  = '0;
        size_cfg = TABLE_SIZE_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
            slot_keys[i] = '0;

        // fresh table: first lookups miss, writes echo slot and key, then both hit
        add_row(0, 0, REQ_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 8'h00, 1, 0, 8'h00, 32'h0);
        add_row(0, 0, REQ_LOOKUP, '1, '1, '1, 8'hFF, 1, 0, 8'h00, 32'h0);
        add_row(0, 0, REQ_WRITE, '1, '1, '1, 8'hFF, 1, 1, 8'hFF, '1);
        add_row(0, 0, REQ_WRITE, 32'h1, 32'h0, 32'h0, 8'h00, 1, 1, 8'h00, 32'h1);
        add_row(0, 0, REQ_LOOKUP, '1, 32'hFF, 32'h0, 8'h00, 0, 0, 8'h00, 32'h0);
        add_row(0, 0, REQ_LOOKUP, 32'h1, 32'h0, '1, 8'h00, 0, 0, 8'h00, 32'h0);
        // two-step chain, key zero lookup, then break the chain with a delete
        add_row(0, 0, REQ_WRITE, 32'hA5A5_A5A5, 32'h0, 32'h0, 8'h07, 1, 1, 8'h07,
                32'hA5A5_A5A5);
        add_row(0, 0, REQ_WRITE, 32'h5A5A_5A5A, 32'h0, 32'h0, 8'h08, 1, 1, 8'h08,
                32'h5A5A_5A5A);
        add_row(0, 0, REQ_LOOKUP, 32'h5A5A_5A5A, 32'h7, 32'h1, 8'h00, 0, 0, 8'h00, 32'h0);
        add_row(0, 0, REQ_LOOKUP, 32'h0, 32'h7, 32'h1, 8'h00, 0, 0, 8'h00, 32'h0);
        add_row(0, 0, REQ_WRITE, 32'h0, 32'h0, 32'h0, 8'h08, 1, 1, 8'h08, 32'h0);
        add_row(0, 0, REQ_LOOKUP, 32'h5A5A_5A5A, 32'h7, 32'h1, 8'h00, 0, 0, 8'h00, 32'h0);
        // size extremes: one slot, zero slots, saturation
        add_row(1, 1, REQ_LOOKUP, 32'h1, '1, '1, 8'h00, 0, 0, 8'h00, 32'h0);
        add_row(1, 0, REQ_LOOKUP, 32'h1, 32'h0, 32'h0, 8'h00, 1, 0, 8'h00, 32'h0);
        add_row(0, 0, REQ_WRITE, 32'h77, 32'h0, 32'h0, 8'hC8, 1, 1, 8'hC8, 32'h77);
        add_row(1, 511, REQ_LOOKUP, 32'h77, 32'hC8, 32'h0, 8'h00, 0, 0, 8'h00, 32'h0);
        add_row(0, 0, REQ_WRITE, 32'h11, 32'h0, 32'h0, 8'h01, 1, 1, 8'h01, 32'h11);
        add_row(0, 0, REQ_WRITE, 32'h22, 32'h0, 32'h0, 8'h02, 1, 1, 8'h02, 32'h22);
        // full three-slot table: probes run out; upper pwdata bits are dropped
        add_row(1, 32'hA5A5_A003, REQ_LOOKUP, 32'h33, 32'h5, 32'h1, 8'h00, 0, 0, 8'h00,
                32'h0);
        add_row(0, 0, REQ_LOOKUP, 32'h22, '1, 32'h1, 8'h00, 0, 0, 8'h00, 32'h0);
        add_row(1, 2, REQ_LOOKUP, 32'h22, 32'h1, 32'h3, 8'h00, 0, 0, 8'h00, 32'h0);
        add_row(1, 256, REQ_LOOKUP, '1, '1, 32'h8000_0000, 8'h00, 0, 0, 8'h00, 32'h0);

        pool_key[0] = '1;
        pool_h1[0]  = '1;
        pool_h2[0]  = '1;
        pool_key[1] = 32'h1;
        pool_h1[1]  = 32'h0;
        pool_h2[1]  = 32'h0;
        for (int i = 2; i < POOL_N; i++)
        begin
            do
                k = $urandom;
            while (k == '0);
            pool_key[i] = k;
            pool_h1[i]  = $urandom;
            pool_h2[i]  = $urandom;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            if (row.cfg_en)
                set_table_size(row.cfg_val);
            drive_item(row.req, row.key, row.h1, row.h2, row.slot, row.typed, row.want);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_table_size(PHASE_SIZES[ph]);
            idle_pct = PHASE_IDLE[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                pidx = $urandom_range(0, POOL_N - 1);
                if (pick < 35)
                begin
                    // insert at the first free slot of the key's probe path
                    free = free_slot(pool_h1[pidx], pool_h2[pidx]);
                    if (free >= 0)
                        slot = free[POS_W-1:0];
                    else
                        slot = $urandom_range(0, TABLE_DEPTH - 1);
                    drive_item(REQ_WRITE, pool_key[pidx], $urandom, $urandom, slot, 0,
                               no_want);
                end
                else if (pick < 75)
                    drive_item(REQ_LOOKUP, pool_key[pidx], pool_h1[pidx], pool_h2[pidx],
                               $urandom, 0, no_want);
                else if (pick < 85)
                    drive_item(REQ_LOOKUP, $urandom, $urandom, $urandom, $urandom, 0,
                               no_want);
                else if (pick < 93)
                begin
                    // stray write, a quarter of them emptying the slot
                    k = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
                    drive_item(REQ_WRITE, k, $urandom, $urandom, $urandom, 0, no_want);
                end
                else
                    drive_item(REQ_LOOKUP, '0, $urandom, $urandom, $urandom, 0, no_want);
            end
        end

        start <= 1'b0;
        drain  = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results still pending", pending_results.size(), 0);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
hdl/dhp_pkg.sv
hdl/dhp_rem_lane.sv
hdl/dhp_datapath.sv
hdl/dhp_ctrl.sv
hdl/double_hash_probe_lookup.sv
hdl/dhp_checker.sv
test/tb.sv
